// ===== src/eth_ip_l4_header_parser_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Ethernet / IP / L4 header parser
// Concurrent assertion wrappers clocked on i_clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef ETH_IP_L4_HEADER_PARSER_ASSERT_SVH
`define ETH_IP_L4_HEADER_PARSER_ASSERT_SVH

// Checks a property at every rising edge while the block is out of reset.
`define ETH_L4_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that a condition leads to another one in the following cycle.
`define ETH_L4_ASSERT_NEXT(label, cond, expect_next, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expect_next)) else $error(msg);

`endif

// ===== src/eth_l4_pkg.sv =====
// ----------------------------------------------------------------------------
// eth_l4_pkg
// Shared constants and types of the Ethernet / IP / L4 header parser.
// ----------------------------------------------------------------------------
package eth_l4_pkg;

    // Field widths of the request and result channels.
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 3;
    localparam int OFFSET_W = 12;
    localparam int PORT_W   = 16;

    // Default frame size limit.
    localparam int MAX_FRAME_BYTES_DEF = 2048;

    // Header layout.
    localparam logic [15:0] ETH_KIND_IPV4    = 16'h0800;
    localparam logic [15:0] ETH_KIND_IPV6    = 16'h86DD;
    localparam logic [7:0]  PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PROTO_UDP        = 8'd17;
    localparam logic [6:0]  ETH_HEADER_BYTES = 7'd14;
    localparam logic [6:0]  IPV6_TRANSPORT   = 7'd54;
    localparam logic [7:0]  UDP_HEADER_BYTES = 8'd8;
    localparam logic [7:0]  TCP_MIN_BYTES    = 8'd13;

    // Byte positions of interest.
    localparam int POS_ETYPE_HI   = 12;
    localparam int POS_ETYPE_LO   = 13;
    localparam int POS_IPV4_IHL   = 14;
    localparam int POS_IPV6_NEXT  = 20;
    localparam int POS_IPV4_PROTO = 23;
    localparam int POS_TCP_DOFF   = 12;

    // Minimum frame lengths for the EtherType and protocol bytes.
    localparam int LEN_ETYPE      = 14;
    localparam int LEN_IPV4_PROTO = 24;
    localparam int LEN_IPV6_NEXT  = 21;

    // Parse status codes.
    localparam logic [STATUS_W-1:0] ST_TCP           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UDP           = 3'd1;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN_ETYPE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN_PROTO = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TRUNCATED     = 3'd4;

    // One result of the parser.
    typedef struct packed {
        logic [STATUS_W-1:0] parse_status;
        logic                is_udp;
        logic [OFFSET_W-1:0] payload_offset;
        logic [OFFSET_W-1:0] payload_bytes;
        logic [PORT_W-1:0]   source_port;
        logic [PORT_W-1:0]   dest_port;
    } t_result;

endpackage

// ===== src/eth_l4_ifs.sv =====
// ----------------------------------------------------------------------------
// eth_l4 channel interfaces
// Valid/ready channels for frame bytes in and parse results out.
// ----------------------------------------------------------------------------

// Frame byte channel.
interface eth_l4_in_if;
    logic                          valid;
    logic                          ready;
    logic [eth_l4_pkg::BYTE_W-1:0] frame_byte;
    logic                          last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// Parse result channel.
interface eth_l4_out_if;
    logic                            valid;
    logic                            ready;
    logic [eth_l4_pkg::STATUS_W-1:0] parse_status;
    logic                            is_udp;
    logic [eth_l4_pkg::OFFSET_W-1:0] payload_offset;
    logic [eth_l4_pkg::OFFSET_W-1:0] payload_bytes;
    logic [eth_l4_pkg::PORT_W-1:0]   source_port;
    logic [eth_l4_pkg::PORT_W-1:0]   dest_port;

    modport source (output valid, output parse_status, output is_udp, output payload_offset,
                    output payload_bytes, output source_port, output dest_port,
                    input ready);
    modport sink   (input valid, input parse_status, input is_udp, input payload_offset,
                    input payload_bytes, input source_port, input dest_port,
                    output ready);
endinterface

// ===== src/eth_ip_l4_header_parser.sv =====
// ----------------------------------------------------------------------------
// eth_ip_l4_header_parser
// Streams an Ethernet frame byte by byte and reports the IPv4/IPv6 transport
// (TCP or UDP), the payload offset and length, and the UDP ports.
// ----------------------------------------------------------------------------
// The parser takes one frame byte per cycle with no gaps needed between
// frames. Each byte is registered, then updates the per-frame header state;
// on the byte marked last a single result is built and held in an output
// register, valid once that byte has left the input register. Input
// backpressure only arises when a finished result is still waiting downstream
// and another last byte wants to leave the input register. Frames longer than
// MAX_FRAME_BYTES are counted as exactly MAX_FRAME_BYTES long. VLAN tags and
// IPv6 extension headers are not recognized; the IPv6 transport header is
// taken at byte 54.
`include "eth_ip_l4_header_parser_assert.svh"

module eth_ip_l4_header_parser #(
    parameter int MAX_FRAME_BYTES = eth_l4_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    eth_l4_in_if.sink     i_frame,
    eth_l4_out_if.source  o_result
);
    import eth_l4_pkg::*;

    // Position counter width and the width used for length compares.
    localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CW = (PW > 8) ? PW : 8;

    // Input register.
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;

    // Per-frame header state.
    logic [PW-1:0] r_pos;
    logic [15:0]   r_ether;
    logic [7:0]    r_proto;
    logic [6:0]    r_ts;
    logic [3:0]    r_words;
    logic [15:0]   r_src;
    logic [15:0]   r_dst;

    logic [PW-1:0] n_pos;
    logic [15:0]   n_ether;
    logic [7:0]    n_proto;
    logic [6:0]    n_ts;
    logic [3:0]    n_words;
    logic [15:0]   n_src;
    logic [15:0]   n_dst;

    // Output register.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic out_free;
    logic s1_go;
    logic in_take;

    // Handshake: a last byte needs a free output slot, other bytes always move.
    assign out_free      = !r_out_valid || o_result.ready;
    assign s1_go         = r_s1_valid && (!r_s1_last || out_free);
    assign i_frame.ready = !r_s1_valid || s1_go;
    assign in_take       = i_frame.valid && i_frame.ready;

    // Input register load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_frame.frame_byte;
            r_s1_last <= i_frame.last_byte;
        end
    end

    // Header field capture for the byte in the input register.
    logic [PW-1:0] ts_pos;
    logic is_v4;
    logic is_v6;

    always_comb begin
        n_ether = r_ether;
        n_ts    = r_ts;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        n_words = r_words;

        if (r_pos == PW'(POS_ETYPE_HI)) begin
            n_ether[15:8] = r_s1_byte;
        end
        if (r_pos == PW'(POS_ETYPE_LO)) begin
            n_ether[7:0] = r_s1_byte;
            if ({r_ether[15:8], r_s1_byte} == ETH_KIND_IPV6) begin
                n_ts = IPV6_TRANSPORT;
            end
        end
        if (r_pos == PW'(POS_IPV4_IHL) && r_ether == ETH_KIND_IPV4) begin
            n_ts = ETH_HEADER_BYTES + 7'({r_s1_byte[3:0], 2'b00});
        end
        if (r_pos == PW'(POS_IPV4_PROTO) && r_ether == ETH_KIND_IPV4) begin
            n_proto = r_s1_byte;
        end
        if (r_pos == PW'(POS_IPV6_NEXT) && r_ether == ETH_KIND_IPV6) begin
            n_proto = r_s1_byte;
        end

        ts_pos = PW'(n_ts);
        if (r_pos == ts_pos) begin
            n_src[15:8] = r_s1_byte;
        end
        if (r_pos == ts_pos + PW'(1)) begin
            n_src[7:0] = r_s1_byte;
        end
        if (r_pos == ts_pos + PW'(2)) begin
            n_dst[15:8] = r_s1_byte;
        end
        if (r_pos == ts_pos + PW'(3)) begin
            n_dst[7:0] = r_s1_byte;
        end
        if (r_pos == ts_pos + PW'(POS_TCP_DOFF)) begin
            n_words = r_s1_byte[7:4];
        end

        n_pos = (r_pos < PW'(MAX_FRAME_BYTES)) ? r_pos + PW'(1) : r_pos;
    end

    // Result for a frame that ends with the byte in the input register.
    logic [PW:0]   len_sum;
    logic [CW-1:0] len;
    logic [CW-1:0] udp_off;
    logic [CW-1:0] tcp_off;
    logic [CW-1:0] tcp_min;
    logic [CW-1:0] sel_off;

    always_comb begin
        len_sum = {1'b0, r_pos} + (PW+1)'(1);
        len     = (len_sum > (PW+1)'(MAX_FRAME_BYTES)) ? CW'(MAX_FRAME_BYTES)
                                                      : CW'(len_sum);
        udp_off = CW'({1'b0, n_ts} + UDP_HEADER_BYTES);
        tcp_off = CW'({1'b0, n_ts} + {2'b00, n_words, 2'b00});
        tcp_min = CW'({1'b0, n_ts} + TCP_MIN_BYTES);
        is_v4   = (n_ether == ETH_KIND_IPV4);
        is_v6   = (n_ether == ETH_KIND_IPV6);

        n_out   = '0;
        sel_off = '0;
        if (len < CW'(LEN_ETYPE)) begin
            n_out.parse_status = ST_TRUNCATED;
        end else if (!is_v4 && !is_v6) begin
            n_out.parse_status = ST_UNKNOWN_ETYPE;
        end else if (len < (is_v4 ? CW'(LEN_IPV4_PROTO) : CW'(LEN_IPV6_NEXT))) begin
            n_out.parse_status = ST_TRUNCATED;
        end else if (n_proto == PROTO_UDP) begin
            if (len < udp_off) begin
                n_out.parse_status = ST_TRUNCATED;
            end else begin
                n_out.parse_status = ST_UDP;
                n_out.is_udp       = 1'b1;
                n_out.source_port  = n_src;
                n_out.dest_port    = n_dst;
                sel_off            = udp_off;
            end
        end else if (n_proto == PROTO_TCP) begin
            if (len < tcp_min || len < tcp_off) begin
                n_out.parse_status = ST_TRUNCATED;
            end else begin
                n_out.parse_status = ST_TCP;
                sel_off            = tcp_off;
            end
        end else begin
            n_out.parse_status = ST_UNKNOWN_PROTO;
        end

        // Offset is zero when nothing was parsed, which also zeroes the length.
        n_out.payload_offset = OFFSET_W'(sel_off);
        n_out.payload_bytes  = (sel_off == '0) ? '0 : OFFSET_W'(len - sel_off);
    end

    // Header state update; everything returns to zero after the last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_ether <= '0;
            r_proto <= '0;
            r_ts    <= '0;
            r_words <= '0;
            r_src   <= '0;
            r_dst   <= '0;
        end else if (s1_go) begin
            if (r_s1_last) begin
                r_pos   <= '0;
                r_ether <= '0;
                r_proto <= '0;
                r_ts    <= '0;
                r_words <= '0;
                r_src   <= '0;
                r_dst   <= '0;
            end else begin
                r_pos   <= n_pos;
                r_ether <= n_ether;
                r_proto <= n_proto;
                r_ts    <= n_ts;
                r_words <= n_words;
                r_src   <= n_src;
                r_dst   <= n_dst;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_last) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.parse_status   = r_out.parse_status;
    assign o_result.is_udp         = r_out.is_udp;
    assign o_result.payload_offset = r_out.payload_offset;
    assign o_result.payload_bytes  = r_out.payload_bytes;
    assign o_result.source_port    = r_out.source_port;
    assign o_result.dest_port      = r_out.dest_port;

    // Checks.
    `ETH_L4_ASSERT(a_udp_flag, !r_out_valid || (r_out.is_udp == (r_out.parse_status == ST_UDP)), "is_udp disagrees with status")
    `ETH_L4_ASSERT(a_unparsed_zero, !r_out_valid || r_out.parse_status == ST_TCP || r_out.parse_status == ST_UDP || (r_out.payload_offset == '0 && r_out.payload_bytes == '0), "unparsed frame has offset or length")
    `ETH_L4_ASSERT(a_pos_cap, r_pos <= PW'(MAX_FRAME_BYTES), "byte position past the frame limit")
    `ETH_L4_ASSERT_NEXT(a_frame_clear, s1_go && r_s1_last, r_pos == '0 && r_ether == '0, "frame state not cleared after last byte")
    `ETH_L4_ASSERT_NEXT(a_result_out, s1_go && r_s1_last, r_out_valid, "last byte gave no result")

endmodule

// ===== test/tb_eth_ip_l4_header_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_eth_ip_l4_header_parser
// Self-checking bench for the Ethernet / IP / L4 header parser. Frames are
// streamed one byte per request, and a cycle-free model of the header state
// predicts the single result each frame produces. Directed frames hit the
// length boundaries and the header field extremes. Random frames follow,
// mostly well-formed IPv4/IPv6 TCP/UDP with random content, plus truncated
// frames and noise. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_eth_ip_l4_header_parser;
    import eth_l4_pkg::*;

    localparam int WORD_BYTES   = 4;
    localparam int RAND_BYTES   = 230;
    localparam int RAND_FRAMES  = 4;
    localparam int SETTLE_TICKS = 8;

    // One byte waiting to be sent; drain holds it until all results are in.
    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        bit                drain;
    } t_frame_byte;

    logic i_clk;
    logic i_rst_n;

    eth_l4_in_if  frame_if ();
    eth_l4_out_if result_if ();

    eth_ip_l4_header_parser u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_frame  (frame_if),
        .o_result (result_if)
    );

    t_frame_byte pending_bytes[$];
    t_result     expected_results[$];

    // Header state tracked alongside the parser.
    int                  hp_pos    = 0;
    logic [15:0]         hp_etype  = '0;
    logic [7:0]          hp_proto  = '0;
    logic [6:0]          hp_tstart = '0;
    logic [3:0]          hp_doff   = '0;
    logic [PORT_W-1:0]   hp_sport  = '0;
    logic [PORT_W-1:0]   hp_dport  = '0;

    bit byte_taken   = 1'b0;
    int cycle_cnt    = 0;
    int fail_count   = 0;
    int results_seen = 0;
    int frames_queued = 0;
    int bytes_queued = 0;
    int drain_pauses = 0;
    int status_seen[5];

    // Clock.
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Applies one frame byte to the header state and builds the result on the last byte.
    function automatic bit parse_byte(input logic [7:0] b, input logic last,
                                      output t_result res);
        int          pos;
        int          ts;
        int          len;
        int          offset;
        logic [2:0]  status;
        bit          is_v4;
        bit          is_v6;
        pos = hp_pos;
        res = '0;
        if (pos == POS_ETYPE_HI) hp_etype[15:8] = b;
        if (pos == POS_ETYPE_LO) begin
            hp_etype[7:0] = b;
            if (hp_etype == ETH_KIND_IPV6) hp_tstart = IPV6_TRANSPORT;
        end
        is_v4 = (hp_etype == ETH_KIND_IPV4);
        is_v6 = (hp_etype == ETH_KIND_IPV6);
        if (pos == POS_IPV4_IHL && is_v4)
            hp_tstart = 7'(int'(ETH_HEADER_BYTES) + WORD_BYTES * int'(b[3:0]));
        if (pos == POS_IPV4_PROTO && is_v4) hp_proto = b;
        if (pos == POS_IPV6_NEXT && is_v6) hp_proto = b;

        // Transport fields are picked up relative to the current header start.
        ts = int'(hp_tstart);
        if (pos == ts)                hp_sport[15:8] = b;
        if (pos == ts + 1)            hp_sport[7:0]  = b;
        if (pos == ts + 2)            hp_dport[15:8] = b;
        if (pos == ts + 3)            hp_dport[7:0]  = b;
        if (pos == ts + POS_TCP_DOFF) hp_doff        = b[7:4];

        if (hp_pos < MAX_FRAME_BYTES_DEF) hp_pos++;
        if (!last) return 1'b0;

        len = (pos + 1 > MAX_FRAME_BYTES_DEF) ? MAX_FRAME_BYTES_DEF : pos + 1;
        offset = 0;
        if (len < LEN_ETYPE) begin
            status = ST_TRUNCATED;
        end else if (!is_v4 && !is_v6) begin
            status = ST_UNKNOWN_ETYPE;
        end else if (len < (is_v4 ? LEN_IPV4_PROTO : LEN_IPV6_NEXT)) begin
            status = ST_TRUNCATED;
        end else if (hp_proto == PROTO_UDP) begin
            offset = ts + int'(UDP_HEADER_BYTES);
            if (len < offset) begin
                status = ST_TRUNCATED;
                offset = 0;
            end else begin
                status = ST_UDP;
            end
        end else if (hp_proto == PROTO_TCP) begin
            offset = ts + WORD_BYTES * int'(hp_doff);
            if (len < ts + int'(TCP_MIN_BYTES) || len < offset) begin
                status = ST_TRUNCATED;
                offset = 0;
            end else begin
                status = ST_TCP;
            end
        end else begin
            status = ST_UNKNOWN_PROTO;
        end

        res.parse_status = status;
        res.is_udp       = (status == ST_UDP);
        if (status == ST_UDP || status == ST_TCP) begin
            res.payload_offset = OFFSET_W'(offset);
            res.payload_bytes  = OFFSET_W'(len - offset);
        end
        if (status == ST_UDP) begin
            res.source_port = hp_sport;
            res.dest_port   = hp_dport;
        end

        // Every frame starts from a clean header state.
        hp_pos    = 0;
        hp_etype  = '0;
        hp_proto  = '0;
        hp_tstart = '0;
        hp_doff   = '0;
        hp_sport  = '0;
        hp_dport  = '0;
        return 1'b1;
    endfunction

    // Builds a frame of random bytes with the given header fields and queues it.
    task automatic queue_frame(input logic [15:0] etype, input logic [7:0] proto,
                               input int ihl, input int doff, input int len,
                               input logic [15:0] sport, input logic [15:0] dport,
                               input bit drain);
        logic [7:0]  fb[];
        int          ts;
        t_frame_byte item;
        fb = new[len];
        foreach (fb[i]) fb[i] = 8'($urandom);
        ts = (etype == ETH_KIND_IPV6) ? int'(IPV6_TRANSPORT)
                                      : int'(ETH_HEADER_BYTES) + WORD_BYTES * ihl;
        // Transport fields first, so the IP fields win where the two overlap.
        if (etype == ETH_KIND_IPV4 || etype == ETH_KIND_IPV6) begin
            if (ts < len)                fb[ts]     = sport[15:8];
            if (ts + 1 < len)            fb[ts + 1] = sport[7:0];
            if (ts + 2 < len)            fb[ts + 2] = dport[15:8];
            if (ts + 3 < len)            fb[ts + 3] = dport[7:0];
            if (ts + POS_TCP_DOFF < len)
                fb[ts + POS_TCP_DOFF] = {4'(doff), fb[ts + POS_TCP_DOFF][3:0]};
        end
        if (POS_ETYPE_HI < len) fb[POS_ETYPE_HI] = etype[15:8];
        if (POS_ETYPE_LO < len) fb[POS_ETYPE_LO] = etype[7:0];
        if (etype == ETH_KIND_IPV4) begin
            if (POS_IPV4_IHL < len)   fb[POS_IPV4_IHL]   = {fb[POS_IPV4_IHL][7:4], 4'(ihl)};
            if (POS_IPV4_PROTO < len) fb[POS_IPV4_PROTO] = proto;
        end else if (etype == ETH_KIND_IPV6) begin
            if (POS_IPV6_NEXT < len) fb[POS_IPV6_NEXT] = proto;
        end
        for (int i = 0; i < len; i++) begin
            item.data  = fb[i];
            item.last  = (i == len - 1);
            item.drain = drain && (i == 0);
            pending_bytes.push_back(item);
        end
        frames_queued++;
        bytes_queued += len;
    endtask

    // Random idling on either side, switched off for a stretch of results.
    function automatic bit take_break();
        if (results_seen >= 8 && results_seen < 20) return 1'b0;
        return $urandom_range(99) < 11;
    endfunction

    // Sender and receiver: change inputs on the falling edge.
    always @(negedge i_clk) begin : drive_frames
        t_frame_byte nxt;
        bit          send;
        if (i_rst_n) begin
            if (!frame_if.valid || byte_taken) begin
                send = 1'b0;
                if (pending_bytes.size() != 0) begin
                    if (pending_bytes[0].drain && expected_results.size() != 0)
                        send = 1'b0;
                    else
                        send = !take_break();
                end
                if (send) begin
                    nxt = pending_bytes.pop_front();
                    if (nxt.drain) drain_pauses++;
                    frame_if.frame_byte <= nxt.data;
                    frame_if.last_byte  <= nxt.last;
                end
                frame_if.valid <= send;
            end
            result_if.ready <= !take_break();
        end
    end

    // Observe both channels on the rising edge: predict accepted requests, check results.
    always @(posedge i_clk) begin : watch_channels
        t_result got;
        t_result want;
        cycle_cnt++;
        byte_taken = i_rst_n && frame_if.valid && frame_if.ready;
        if (byte_taken) begin
            if (parse_byte(frame_if.frame_byte, frame_if.last_byte, want))
                expected_results.push_back(want);
        end
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got.parse_status   = result_if.parse_status;
            got.is_udp         = result_if.is_udp;
            got.payload_offset = result_if.payload_offset;
            got.payload_bytes  = result_if.payload_bytes;
            got.source_port    = result_if.source_port;
            got.dest_port      = result_if.dest_port;
            results_seen++;
            if (expected_results.size() == 0) begin
                $error("result with no frame pending: status %0d", got.parse_status);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (want.parse_status <= ST_TRUNCATED) status_seen[want.parse_status]++;
                if (got.parse_status !== want.parse_status) begin
                    $error("parse_status: expected %0d, got %0d",
                           want.parse_status, got.parse_status);
                    fail_count++;
                end
                if (got.is_udp !== want.is_udp) begin
                    $error("is_udp: expected %0d, got %0d", want.is_udp, got.is_udp);
                    fail_count++;
                end
                if (got.payload_offset !== want.payload_offset) begin
                    $error("payload_offset: expected %0d, got %0d",
                           want.payload_offset, got.payload_offset);
                    fail_count++;
                end
                if (got.payload_bytes !== want.payload_bytes) begin
                    $error("payload_bytes: expected %0d, got %0d",
                           want.payload_bytes, got.payload_bytes);
                    fail_count++;
                end
                if (got.source_port !== want.source_port) begin
                    $error("source_port: expected %h, got %h",
                           want.source_port, got.source_port);
                    fail_count++;
                end
                if (got.dest_port !== want.dest_port) begin
                    $error("dest_port: expected %h, got %h", want.dest_port, got.dest_port);
                    fail_count++;
                end
            end
        end
    end

    // Stimulus, reset and end of run.
    initial begin : run_frames
        int          kind;
        int          pick;
        int          ihl;
        int          doff;
        int          need;
        int          len;
        int          ts;
        int          rand_bytes;
        int          rand_frames;
        logic [15:0] etype;
        logic [7:0]  proto;

        i_rst_n             = 1'b0;
        frame_if.valid      = 1'b0;
        frame_if.frame_byte = '0;
        frame_if.last_byte  = 1'b0;
        result_if.ready     = 1'b1;

        // Directed frames: length boundaries and header field extremes.
        queue_frame(16'h1234, 8'h00, 5, 5, 1, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_UDP, 5, 5, 13, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_UDP, 5, 5, 14, 16'h0000, 16'h0000, 1'b0);
        queue_frame(16'h0000, 8'h00, 5, 5, 14, 16'h0000, 16'h0000, 1'b0);
        queue_frame(16'hFFFF, PROTO_TCP, 5, 5, 20, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_frame(16'h86DC, PROTO_UDP, 5, 5, 16, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_UDP, 5, 5, 23, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, 8'hFF, 5, 5, 24, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV6, PROTO_UDP, 5, 5, 20, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV6, 8'h00, 5, 5, 21, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_UDP, 5, 5, 41, 16'hFFFF, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_UDP, 5, 5, 42, 16'h0000, 16'hFFFF, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_TCP, 5, 5, 46, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_TCP, 5, 5, 54, 16'h0000, 16'h0000, 1'b1);
        queue_frame(ETH_KIND_IPV4, PROTO_TCP, 15, 15, 134, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_TCP, 5, 0, 47, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_TCP, 5, 15, 60, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV4, PROTO_UDP, 0, 5, 30, 16'hA5A5, 16'h5A5A, 1'b0);
        queue_frame(ETH_KIND_IPV6, PROTO_UDP, 5, 5, 61, 16'h0000, 16'h0000, 1'b0);
        queue_frame(ETH_KIND_IPV6, PROTO_UDP, 5, 5, 62, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_frame(ETH_KIND_IPV6, PROTO_TCP, 5, 5, 80, 16'h0000, 16'h0000, 1'b0);

        // Random frames, mostly well-formed headers with random content.
        rand_bytes  = 0;
        rand_frames = 0;
        while (rand_bytes < RAND_BYTES || rand_frames < RAND_FRAMES) begin
            kind = $urandom_range(99);
            ihl  = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
            doff = ($urandom_range(3) == 0) ? $urandom_range(15) : 5;
            pick = $urandom_range(9);
            proto = (pick < 4) ? PROTO_UDP : (pick < 8) ? PROTO_TCP : 8'($urandom);
            if (kind < 70) begin
                etype = (kind < 40) ? ETH_KIND_IPV4 : ETH_KIND_IPV6;
                ts = (etype == ETH_KIND_IPV6) ? int'(IPV6_TRANSPORT)
                                              : int'(ETH_HEADER_BYTES) + WORD_BYTES * ihl;
                need = (etype == ETH_KIND_IPV4) ? LEN_IPV4_PROTO : LEN_IPV6_NEXT;
                if (proto == PROTO_UDP && ts + int'(UDP_HEADER_BYTES) > need)
                    need = ts + int'(UDP_HEADER_BYTES);
                if (proto == PROTO_TCP && ts + int'(TCP_MIN_BYTES) > need)
                    need = ts + int'(TCP_MIN_BYTES);
                if (proto == PROTO_TCP && ts + WORD_BYTES * doff > need)
                    need = ts + WORD_BYTES * doff;
                len = need + $urandom_range(24);
                if ($urandom_range(7) == 0) len = $urandom_range(need, 1);
            end else if (kind < 82) begin
                etype = 16'($urandom);
                len = $urandom_range(14, 80);
            end else begin
                // Noise: short frames of any kind.
                pick = $urandom_range(2);
                etype = (pick == 0) ? ETH_KIND_IPV4 : (pick == 1) ? ETH_KIND_IPV6
                                                                 : 16'($urandom);
                len = $urandom_range(1, 40);
            end
            queue_frame(etype, proto, ihl, doff, len, 16'($urandom), 16'($urandom),
                        $urandom_range(29) == 0);
            rand_bytes += len;
            rand_frames++;
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every byte sent, every result back, then let the pipeline settle.
        while (pending_bytes.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
        while (frame_if.valid) @(negedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_TICKS) @(posedge i_clk);

        $display("Sent %0d frames in %0d bytes over %0d cycles, %0d of them after a full drain.",
                 frames_queued, bytes_queued, cycle_cnt, drain_pauses);
        $display("Results: tcp %0d, udp %0d, unknown ethertype %0d, unknown protocol %0d, truncated %0d.",
                 status_seen[ST_TCP], status_seen[ST_UDP], status_seen[ST_UNKNOWN_ETYPE],
                 status_seen[ST_UNKNOWN_PROTO], status_seen[ST_TRUNCATED]);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #6_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/eth_l4_pkg.sv
src/eth_l4_ifs.sv
src/eth_ip_l4_header_parser.sv
test/tb_eth_ip_l4_header_parser.sv
